FILE: sv/exlex_pkg.sv
// Shared types, codes and character constants of the expression lexer.
`default_nettype none

package exlex_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int SLOTS = 4;

   localparam logic [1:0] RK_VALUE = 2'd0;
   localparam logic [1:0] RK_TOKEN = 2'd1;
   localparam logic [1:0] RK_FAULT = 2'd2;
   localparam logic [1:0] RK_END   = 2'd3;

   localparam logic [1:0] FC_DUP_DOT    = 2'd0;
   localparam logic [1:0] FC_OPEN_STR   = 2'd1;
   localparam logic [1:0] FC_UNEXPECTED = 2'd2;

   localparam logic [4:0] TK_IDENT       = 5'd0;
   localparam logic [4:0] TK_INT         = 5'd1;
   localparam logic [4:0] TK_FLOAT       = 5'd2;
   localparam logic [4:0] TK_STRING      = 5'd3;
   localparam logic [4:0] TK_SYMBOL      = 5'd4;
   localparam logic [4:0] TK_TYPE        = 5'd5;
   localparam logic [4:0] TK_TYPE_COLON  = 5'd6;
   localparam logic [4:0] TK_BIND        = 5'd7;
   localparam logic [4:0] TK_STRUCT_BIND = 5'd8;
   localparam logic [4:0] TK_STRUCT_GET  = 5'd9;
   localparam logic [4:0] TK_ADD         = 5'd10;
   localparam logic [4:0] TK_SUB         = 5'd11;
   localparam logic [4:0] TK_MUL         = 5'd12;
   localparam logic [4:0] TK_DIV         = 5'd13;
   localparam logic [4:0] TK_POW         = 5'd14;
   localparam logic [4:0] TK_SEPARATOR   = 5'd15;
   localparam logic [4:0] TK_SEMICOLON   = 5'd16;
   localparam logic [4:0] TK_COMBINE     = 5'd17;
   localparam logic [4:0] TK_OPEN_PAREN  = 5'd18;
   localparam logic [4:0] TK_CLOSE_PAREN = 5'd19;
   localparam logic [4:0] TK_OPEN_FUNC   = 5'd20;
   localparam logic [4:0] TK_CLOSE_FUNC  = 5'd21;
   localparam logic [4:0] TK_OPEN_LIST   = 5'd22;
   localparam logic [4:0] TK_CLOSE_LIST  = 5'd23;

   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_BAR     = 8'h7C;
   localparam logic [7:0] CH_EQUALS  = 8'h3D;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_CARET   = 8'h5E;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_LBRACK  = 8'h5B;
   localparam logic [7:0] CH_RBRACK  = 8'h5D;
   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;
   localparam logic [7:0] CH_GREATER = 8'h3E;
   localparam logic [7:0] CH_UNDER   = 8'h5F;
   localparam logic [7:0] CH_DOT     = 8'h2E;

   typedef struct packed {
      logic [1:0] result_kind;
      logic [4:0] token_kind;
      logic [7:0] value_byte;
      logic [1:0] fault_code;
   } slot_type;

   typedef struct packed {
      logic [1:0] last_idx;
      slot_type [SLOTS-1:0] slot;
   } bundle_type;

endpackage

`default_nettype wire

FILE: sv/exlex_if.sv
// Valid/ready channel interfaces for source bytes and result items.
`default_nettype none

interface exlex_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       text_end;

   modport source (output valid, output char_code, output text_end, input ready);
   modport sink (input valid, input char_code, input text_end, output ready);
endinterface

interface exlex_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] result_kind;
   logic [4:0] token_kind;
   logic [7:0] value_byte;
   logic [1:0] fault_code;
   logic       run_last;

   modport source (output valid, output result_kind, output token_kind,
                   output value_byte, output fault_code, output run_last, input ready);
   modport sink (input valid, input result_kind, input token_kind,
                 input value_byte, input fault_code, input run_last, output ready);
endinterface

`default_nettype wire

FILE: sv/exlex_front.sv
// Front end: accepts one byte per cycle while accept is high and scans it into a bundle of result items.
`default_nettype none

module exlex_front
   import exlex_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] char_code,
   input  wire logic       text_end,
   output bundle_type      bundle,
   output logic            bundle_valid
);

   typedef enum logic [3:0] {
      M_IDLE, M_NUM, M_IDENT, M_TYPE, M_SYM, M_STR, M_MINUS, M_COLON, M_PAREN, M_COMMENT
   } mode_type;

   typedef struct packed {
      mode_type   mode;
      logic       emit;
      logic [1:0] rk;
      logic [4:0] tk;
      logic [1:0] fc;
   } fresh_type;

   mode_type mode_ff, mode_in;
   logic     atc_ff, atc_in;
   logic     dot_ff, dot_in;
   logic     star_ff, star_in;
   logic     fault_ff, fault_in;

   slot_type  slot_v [SLOTS];
   logic [2:0] n_v;
   logic       fresh_v;
   fresh_type  fr_v;

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic slot_type mk(input logic [1:0] rk, input logic [4:0] tk,
                                   input logic [7:0] vb, input logic [1:0] fc);
      slot_type s;
      s.result_kind = rk;
      s.token_kind  = tk;
      s.value_byte  = vb;
      s.fault_code  = fc;
      return s;
   endfunction

   function automatic fresh_type start_fresh(input logic [7:0] c, input logic atc);
      fresh_type f;
      f.mode = M_IDLE;
      f.emit = 1'b1;
      f.rk   = RK_TOKEN;
      f.tk   = TK_IDENT;
      f.fc   = FC_DUP_DOT;
      if (c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE) begin
         f.emit = 1'b0;
      end else if (is_digit(c)) begin
         f.mode = M_NUM;
         f.rk   = RK_VALUE;
         f.tk   = TK_INT;
      end else if (is_alpha(c)) begin
         f.mode = atc ? M_TYPE : M_IDENT;
         f.rk   = RK_VALUE;
         f.tk   = atc ? TK_TYPE : TK_IDENT;
      end else begin
         unique case (c)
            CH_HASH: begin
               f.mode = M_SYM;
               f.rk   = RK_VALUE;
               f.tk   = TK_SYMBOL;
            end
            CH_QUOTE: begin
               f.mode = M_STR;
               f.emit = 1'b0;
            end
            CH_MINUS: begin
               f.mode = M_MINUS;
               f.emit = 1'b0;
            end
            CH_COLON: begin
               f.mode = M_COLON;
               f.emit = 1'b0;
            end
            CH_LPAREN: begin
               f.mode = M_PAREN;
               f.emit = 1'b0;
            end
            CH_BAR:    f.tk = TK_COMBINE;
            CH_EQUALS: f.tk = TK_STRUCT_BIND;
            CH_PLUS:   f.tk = TK_ADD;
            CH_STAR:   f.tk = TK_MUL;
            CH_SLASH:  f.tk = TK_DIV;
            CH_CARET:  f.tk = TK_POW;
            CH_COMMA:  f.tk = TK_SEPARATOR;
            CH_SEMI:   f.tk = TK_SEMICOLON;
            CH_RPAREN: f.tk = TK_CLOSE_PAREN;
            CH_LBRACK: f.tk = TK_OPEN_FUNC;
            CH_RBRACK: f.tk = TK_CLOSE_FUNC;
            CH_LBRACE: f.tk = TK_OPEN_LIST;
            CH_RBRACE: f.tk = TK_CLOSE_LIST;
            default: begin
               f.rk = RK_FAULT;
               f.fc = FC_UNEXPECTED;
            end
         endcase
      end
      return f;
   endfunction

   always_comb begin
      mode_in  = mode_ff;
      atc_in   = atc_ff;
      dot_in   = dot_ff;
      star_in  = star_ff;
      fault_in = fault_ff;
      slot_v   = '{default: '0};
      n_v      = 3'd0;
      fresh_v  = 1'b0;
      fr_v     = start_fresh(char_code, 1'b0);

      if (!fault_ff) begin
         unique case (mode_ff)
            M_NUM: begin
               if (char_code == CH_DOT) begin
                  if (dot_ff) begin
                     slot_v[0] = mk(RK_FAULT, TK_IDENT, 8'd0, FC_DUP_DOT);
                     n_v       = 3'd1;
                     fault_in  = 1'b1;
                     mode_in   = M_IDLE;
                  end else begin
                     dot_in    = 1'b1;
                     slot_v[0] = mk(RK_VALUE, TK_FLOAT, char_code, FC_DUP_DOT);
                     n_v       = 3'd1;
                  end
               end else if (is_digit(char_code)) begin
                  slot_v[0] = mk(RK_VALUE, dot_ff ? TK_FLOAT : TK_INT, char_code, FC_DUP_DOT);
                  n_v       = 3'd1;
               end else begin
                  slot_v[0] = mk(RK_TOKEN, dot_ff ? TK_FLOAT : TK_INT, 8'd0, FC_DUP_DOT);
                  n_v       = 3'd1;
                  atc_in    = 1'b0;
                  dot_in    = 1'b0;
                  fresh_v   = 1'b1;
               end
            end
            M_IDENT, M_SYM: begin
               if (is_digit(char_code) || is_alpha(char_code) || char_code == CH_UNDER) begin
                  slot_v[0] = mk(RK_VALUE, (mode_ff == M_SYM) ? TK_SYMBOL : TK_IDENT,
                                 char_code, FC_DUP_DOT);
                  n_v       = 3'd1;
               end else begin
                  slot_v[0] = mk(RK_TOKEN, (mode_ff == M_SYM) ? TK_SYMBOL : TK_IDENT,
                                 8'd0, FC_DUP_DOT);
                  n_v       = 3'd1;
                  atc_in    = 1'b0;
                  fresh_v   = 1'b1;
               end
            end
            M_TYPE: begin
               if (is_digit(char_code) || is_alpha(char_code)) begin
                  slot_v[0] = mk(RK_VALUE, TK_TYPE, char_code, FC_DUP_DOT);
                  n_v       = 3'd1;
               end else begin
                  slot_v[0] = mk(RK_TOKEN, TK_TYPE, 8'd0, FC_DUP_DOT);
                  n_v       = 3'd1;
                  atc_in    = 1'b0;
                  fresh_v   = 1'b1;
               end
            end
            M_STR: begin
               if (char_code == CH_QUOTE) begin
                  slot_v[0] = mk(RK_TOKEN, TK_STRING, 8'd0, FC_DUP_DOT);
                  atc_in    = 1'b0;
                  mode_in   = M_IDLE;
               end else begin
                  slot_v[0] = mk(RK_VALUE, TK_STRING, char_code, FC_DUP_DOT);
               end
               n_v = 3'd1;
            end
            M_MINUS: begin
               n_v    = 3'd1;
               atc_in = 1'b0;
               if (char_code == CH_GREATER) begin
                  slot_v[0] = mk(RK_TOKEN, TK_STRUCT_GET, 8'd0, FC_DUP_DOT);
                  mode_in   = M_IDLE;
               end else begin
                  slot_v[0] = mk(RK_TOKEN, TK_SUB, 8'd0, FC_DUP_DOT);
                  fresh_v   = 1'b1;
               end
            end
            M_COLON: begin
               n_v = 3'd1;
               if (char_code == CH_EQUALS) begin
                  slot_v[0] = mk(RK_TOKEN, TK_BIND, 8'd0, FC_DUP_DOT);
                  atc_in    = 1'b0;
                  mode_in   = M_IDLE;
               end else begin
                  slot_v[0] = mk(RK_TOKEN, TK_TYPE_COLON, 8'd0, FC_DUP_DOT);
                  atc_in    = 1'b1;
                  fresh_v   = 1'b1;
               end
            end
            M_PAREN: begin
               if (char_code == CH_STAR) begin
                  mode_in = M_COMMENT;
                  star_in = 1'b0;
               end else begin
                  slot_v[0] = mk(RK_TOKEN, TK_OPEN_PAREN, 8'd0, FC_DUP_DOT);
                  n_v       = 3'd1;
                  atc_in    = 1'b0;
                  fresh_v   = 1'b1;
               end
            end
            M_COMMENT: begin
               if (star_ff && char_code == CH_RPAREN) begin
                  mode_in = M_IDLE;
                  star_in = 1'b0;
               end else begin
                  star_in = (char_code == CH_STAR);
               end
            end
            default: fresh_v = 1'b1;
         endcase

         if (fresh_v) begin
            fr_v    = start_fresh(char_code, atc_in);
            mode_in = fr_v.mode;
            if (fr_v.mode == M_NUM) begin
               dot_in = 1'b0;
            end
            if (fr_v.emit) begin
               slot_v[n_v[1:0]] = mk(fr_v.rk, fr_v.tk,
                                     (fr_v.rk == RK_VALUE) ? char_code : 8'd0, fr_v.fc);
               n_v = n_v + 3'd1;
               if (fr_v.rk == RK_TOKEN) begin
                  atc_in = (fr_v.tk == TK_TYPE_COLON);
               end
               if (fr_v.rk == RK_FAULT) begin
                  fault_in = 1'b1;
               end
            end
         end
      end

      if (text_end) begin
         if (!fault_in) begin
            unique case (mode_in)
               M_NUM: begin
                  slot_v[n_v[1:0]] = mk(RK_TOKEN, dot_in ? TK_FLOAT : TK_INT, 8'd0, FC_DUP_DOT);
                  n_v = n_v + 3'd1;
               end
               M_IDENT: begin
                  slot_v[n_v[1:0]] = mk(RK_TOKEN, TK_IDENT, 8'd0, FC_DUP_DOT);
                  n_v = n_v + 3'd1;
               end
               M_TYPE: begin
                  slot_v[n_v[1:0]] = mk(RK_TOKEN, TK_TYPE, 8'd0, FC_DUP_DOT);
                  n_v = n_v + 3'd1;
               end
               M_SYM: begin
                  slot_v[n_v[1:0]] = mk(RK_TOKEN, TK_SYMBOL, 8'd0, FC_DUP_DOT);
                  n_v = n_v + 3'd1;
               end
               M_STR: begin
                  slot_v[n_v[1:0]] = mk(RK_FAULT, TK_IDENT, 8'd0, FC_OPEN_STR);
                  n_v = n_v + 3'd1;
               end
               M_MINUS: begin
                  slot_v[n_v[1:0]] = mk(RK_TOKEN, TK_SUB, 8'd0, FC_DUP_DOT);
                  n_v = n_v + 3'd1;
               end
               M_COLON: begin
                  slot_v[n_v[1:0]] = mk(RK_TOKEN, TK_TYPE_COLON, 8'd0, FC_DUP_DOT);
                  n_v = n_v + 3'd1;
               end
               M_PAREN: begin
                  slot_v[n_v[1:0]] = mk(RK_TOKEN, TK_OPEN_PAREN, 8'd0, FC_DUP_DOT);
                  n_v = n_v + 3'd1;
               end
               default: ;
            endcase
         end
         slot_v[n_v[1:0]] = mk(RK_END, TK_IDENT, 8'd0, FC_DUP_DOT);
         n_v      = n_v + 3'd1;
         mode_in  = M_IDLE;
         atc_in   = 1'b0;
         dot_in   = 1'b0;
         star_in  = 1'b0;
         fault_in = 1'b0;
      end
   end

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         bundle.slot[i] = slot_v[i];
      end
      bundle.last_idx = n_v[1:0] - 2'd1;
      bundle_valid    = accept && (n_v != 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_IDLE;
         atc_ff   <= 1'b0;
         dot_ff   <= 1'b0;
         star_ff  <= 1'b0;
         fault_ff <= 1'b0;
      end else if (accept) begin
         mode_ff  <= mode_in;
         atc_ff   <= atc_in;
         dot_ff   <= dot_in;
         star_ff  <= star_in;
         fault_ff <= fault_in;
      end
   end

endmodule

`default_nettype wire

FILE: sv/exlex_queue.sv
// Short queue of result bundles between the front and back ends.
`default_nettype none

module exlex_queue
   import exlex_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire bundle_type push_data,
   input  wire logic       pop,
   output bundle_type      head,
   output logic            full,
   output logic            empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bundle_type         store_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: sv/exlex_back.sv
// Back end: drains bundles one result item per cycle, while rsp_bus is ready, into the output register.
`default_nettype none

module exlex_back
   import exlex_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire bundle_type  head,
   input  wire logic        empty,
   output logic             pop,
   exlex_rsp_if.source      rsp_bus
);

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff;
   slot_type   slot_ff;
   logic       last_ff;
   logic       load;
   logic       at_last;

   assign load    = !empty && (!valid_ff || rsp_bus.ready);
   assign at_last = (idx_ff == head.last_idx);
   assign pop     = load && at_last;
   assign idx_in  = at_last ? 2'd0 : idx_ff + 2'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         if (load) begin
            idx_ff <= idx_in;
         end
         if (load) begin
            valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         slot_ff <= head.slot[idx_ff];
         last_ff <= at_last;
      end
   end

   assign rsp_bus.valid       = valid_ff;
   assign rsp_bus.result_kind = slot_ff.result_kind;
   assign rsp_bus.token_kind  = slot_ff.token_kind;
   assign rsp_bus.value_byte  = slot_ff.value_byte;
   assign rsp_bus.fault_code  = slot_ff.fault_code;
   assign rsp_bus.run_last    = last_ff;

endmodule

`default_nettype wire

FILE: sv/expression_language_lexer_core.sv
// A byte's items are registered in the bundle queue and then in the output register.
// Throughput: one byte per cycle while each byte yields at most one item and rsp_bus
// is ready; up to four items of one byte take the single output register in turn.
// Input is taken whenever the bundle queue between the scanner and the drain has room.
// Synchronous reset returns the scanner to idle with no open token and empties the queue.
`default_nettype none

module expression_language_lexer_core
   import exlex_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  wire logic   clock,
   input  wire logic   reset,
   exlex_req_if.sink   req_bus,
   exlex_rsp_if.source rsp_bus
);

   bundle_type bundle;
   bundle_type head;
   logic       bundle_valid;
   logic       full;
   logic       empty;
   logic       pop;
   logic       accept;

   assign req_bus.ready = !full;
   assign accept        = req_bus.valid && !full;

   exlex_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .char_code    (req_bus.char_code),
      .text_end     (req_bus.text_end),
      .bundle       (bundle),
      .bundle_valid (bundle_valid)
   );

   exlex_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (bundle_valid),
      .push_data (bundle),
      .pop       (pop),
      .head      (head),
      .full      (full),
      .empty     (empty)
   );

   exlex_back u_back (
      .clock   (clock),
      .reset   (reset),
      .head    (head),
      .empty   (empty),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule

`default_nettype wire

FILE: bench/tb.sv
// Self-checking testbench for the expression lexer core: byte stream in, result items out.
`timescale 1ns / 100ps

module tb;
   import exlex_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_BYTES = 285;
   localparam int DRAIN_CYCLES = 20;

   localparam logic [1:0] FC_NONE = 2'd0;
   localparam logic [4:0] TK_NONE = 5'd0;

   typedef enum logic [3:0] {
      SCAN_IDLE, SCAN_NUMBER, SCAN_WORD, SCAN_TYPE, SCAN_SYMBOL,
      SCAN_STRING, SCAN_MINUS, SCAN_COLON, SCAN_PAREN, SCAN_COMMENT
   } scan_mode_type;

   typedef struct packed {
      logic [1:0] result_kind;
      logic [4:0] token_kind;
      logic [7:0] value_byte;
      logic [1:0] fault_code;
      logic       run_last;
   } lex_result_type;

   class lexer_scoreboard;
      scan_mode_type  mode;
      bit             type_colon_last;
      bit             dot_seen;
      bit             star_seen;
      bit             halted;
      lex_result_type awaited_results[$];
      lex_result_type byte_results[$];
      int             fail_count;

      function new();
         clear_state();
         fail_count = 0;
      endfunction

      function void clear_state();
         mode = SCAN_IDLE;
         type_colon_last = 1'b0;
         dot_seen = 1'b0;
         star_seen = 1'b0;
         halted = 1'b0;
      endfunction

      function void put(logic [1:0] rk, logic [4:0] tk, logic [7:0] vb, logic [1:0] fc);
         lex_result_type r;
         if (byte_results.size() < 4) begin
            r.result_kind = rk;
            r.token_kind = tk;
            r.value_byte = vb;
            r.fault_code = fc;
            r.run_last = 1'b0;
            byte_results.push_back(r);
         end
      endfunction

      function void emit_value(logic [4:0] tk, logic [7:0] c);
         put(RK_VALUE, tk, c, FC_NONE);
      endfunction

      function void emit_token(logic [4:0] tk);
         put(RK_TOKEN, tk, 8'd0, FC_NONE);
         type_colon_last = (tk == TK_TYPE_COLON);
      endfunction

      function void raise_fault(logic [1:0] fc);
         put(RK_FAULT, TK_NONE, 8'd0, fc);
         halted = 1'b1;
         mode = SCAN_IDLE;
      endfunction

      function bit is_digit(logic [7:0] c);
         return c >= "0" && c <= "9";
      endfunction

      function bit is_alpha(logic [7:0] c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      endfunction

      function void start_token(logic [7:0] c);
         mode = SCAN_IDLE;
         if (c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE) return;
         if (is_digit(c)) begin
            mode = SCAN_NUMBER;
            dot_seen = 1'b0;
            emit_value(TK_INT, c);
            return;
         end
         if (is_alpha(c)) begin
            mode = type_colon_last ? SCAN_TYPE : SCAN_WORD;
            emit_value(type_colon_last ? TK_TYPE : TK_IDENT, c);
            return;
         end
         case (c)
            CH_HASH: begin
               mode = SCAN_SYMBOL;
               emit_value(TK_SYMBOL, c);
            end
            CH_QUOTE:  mode = SCAN_STRING;
            CH_MINUS:  mode = SCAN_MINUS;
            CH_COLON:  mode = SCAN_COLON;
            CH_LPAREN: mode = SCAN_PAREN;
            CH_BAR:    emit_token(TK_COMBINE);
            CH_EQUALS: emit_token(TK_STRUCT_BIND);
            CH_PLUS:   emit_token(TK_ADD);
            CH_STAR:   emit_token(TK_MUL);
            CH_SLASH:  emit_token(TK_DIV);
            CH_CARET:  emit_token(TK_POW);
            CH_COMMA:  emit_token(TK_SEPARATOR);
            CH_SEMI:   emit_token(TK_SEMICOLON);
            CH_RPAREN: emit_token(TK_CLOSE_PAREN);
            CH_LBRACK: emit_token(TK_OPEN_FUNC);
            CH_RBRACK: emit_token(TK_CLOSE_FUNC);
            CH_LBRACE: emit_token(TK_OPEN_LIST);
            CH_RBRACE: emit_token(TK_CLOSE_LIST);
            default:   raise_fault(FC_UNEXPECTED);
         endcase
      endfunction

      function void advance(logic [7:0] c);
         case (mode)
            SCAN_NUMBER: begin
               if (c == CH_DOT) begin
                  if (dot_seen) begin
                     raise_fault(FC_DUP_DOT);
                  end else begin
                     dot_seen = 1'b1;
                     emit_value(TK_FLOAT, c);
                  end
               end else if (is_digit(c)) begin
                  emit_value(dot_seen ? TK_FLOAT : TK_INT, c);
               end else begin
                  emit_token(dot_seen ? TK_FLOAT : TK_INT);
                  dot_seen = 1'b0;
                  start_token(c);
               end
            end
            SCAN_WORD, SCAN_SYMBOL: begin
               if (is_digit(c) || is_alpha(c) || c == CH_UNDER) begin
                  emit_value(mode == SCAN_SYMBOL ? TK_SYMBOL : TK_IDENT, c);
               end else begin
                  emit_token(mode == SCAN_SYMBOL ? TK_SYMBOL : TK_IDENT);
                  start_token(c);
               end
            end
            SCAN_TYPE: begin
               if (is_digit(c) || is_alpha(c)) begin
                  emit_value(TK_TYPE, c);
               end else begin
                  emit_token(TK_TYPE);
                  start_token(c);
               end
            end
            SCAN_STRING: begin
               if (c == CH_QUOTE) begin
                  emit_token(TK_STRING);
                  mode = SCAN_IDLE;
               end else begin
                  emit_value(TK_STRING, c);
               end
            end
            SCAN_MINUS: begin
               if (c == CH_GREATER) begin
                  emit_token(TK_STRUCT_GET);
                  mode = SCAN_IDLE;
               end else begin
                  emit_token(TK_SUB);
                  start_token(c);
               end
            end
            SCAN_COLON: begin
               if (c == CH_EQUALS) begin
                  emit_token(TK_BIND);
                  mode = SCAN_IDLE;
               end else begin
                  emit_token(TK_TYPE_COLON);
                  start_token(c);
               end
            end
            SCAN_PAREN: begin
               if (c == CH_STAR) begin
                  mode = SCAN_COMMENT;
                  star_seen = 1'b0;
               end else begin
                  emit_token(TK_OPEN_PAREN);
                  start_token(c);
               end
            end
            SCAN_COMMENT: begin
               if (star_seen && c == CH_RPAREN) begin
                  mode = SCAN_IDLE;
                  star_seen = 1'b0;
               end else begin
                  star_seen = (c == CH_STAR);
               end
            end
            default: start_token(c);
         endcase
      endfunction

      function void flush_token();
         case (mode)
            SCAN_NUMBER: emit_token(dot_seen ? TK_FLOAT : TK_INT);
            SCAN_WORD:   emit_token(TK_IDENT);
            SCAN_TYPE:   emit_token(TK_TYPE);
            SCAN_SYMBOL: emit_token(TK_SYMBOL);
            SCAN_STRING: raise_fault(FC_OPEN_STR);
            SCAN_MINUS:  emit_token(TK_SUB);
            SCAN_COLON:  emit_token(TK_TYPE_COLON);
            SCAN_PAREN:  emit_token(TK_OPEN_PAREN);
            default: ;
         endcase
      endfunction

      function void lex_byte(logic [7:0] c, bit last);
         byte_results.delete();
         if (!halted) advance(c);
         if (last) begin
            if (!halted) flush_token();
            put(RK_END, TK_NONE, 8'd0, FC_NONE);
            clear_state();
         end
         if (byte_results.size() > 0) byte_results[byte_results.size() - 1].run_last = 1'b1;
         foreach (byte_results[i]) awaited_results.push_back(byte_results[i]);
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         fail_count++;
      endtask

      task compare_field(string name, int got, int want);
         if (got != want) report($sformatf("%s is %0d, should be %0d", name, got, want));
      endtask

      task check_result(lex_result_type got);
         lex_result_type want;
         if ($isunknown(got)) begin
            report($sformatf("result item carries unknown bits: %b", got));
         end
         if (awaited_results.size() == 0) begin
            report($sformatf("result item %b arrived with nothing outstanding", got));
            return;
         end
         want = awaited_results.pop_front();
         compare_field("result_kind", got.result_kind, want.result_kind);
         compare_field("token_kind", got.token_kind, want.token_kind);
         compare_field("value_byte", got.value_byte, want.value_byte);
         compare_field("fault_code", got.fault_code, want.fault_code);
         compare_field("run_last", got.run_last, want.run_last);
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   exlex_req_if req_bus();
   exlex_rsp_if rsp_bus();

   expression_language_lexer_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   lexer_scoreboard scoreboard = new();
   logic [7:0]      text_bytes[$];
   bit              send_burst = 1'b0;
   bit              drain_burst = 1'b0;
   int              cycle_count = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      req_bus.valid = 1'b0;
      req_bus.char_code = CH_SPACE;
      req_bus.text_end = 1'b0;
      rsp_bus.ready = 1'b0;
   end

   task automatic send_byte(logic [7:0] c, bit last);
      int gap;
      gap = send_burst ? 0 : $urandom_range(0, 5);
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.char_code <= c;
      req_bus.text_end <= last;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      scoreboard.lex_byte(c, last);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
   endtask

   function automatic void push_string(string s);
      for (int i = 0; i < s.len(); i++) text_bytes.push_back(s[i]);
   endfunction

   function automatic logic [7:0] rand_digit();
      return 8'($urandom_range("0", "9"));
   endfunction

   function automatic logic [7:0] rand_alpha();
      return $urandom_range(0, 1) ? 8'($urandom_range("a", "z")) : 8'($urandom_range("A", "Z"));
   endfunction

   function automatic logic [7:0] rand_word_char();
      int pick;
      pick = $urandom_range(0, 7);
      if (pick == 0) return CH_UNDER;
      if (pick < 3) return rand_digit();
      return rand_alpha();
   endfunction

   function automatic logic [7:0] rand_content_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE);
      return b;
   endfunction

   function automatic void push_blank();
      case ($urandom_range(0, 2))
         0: text_bytes.push_back(CH_SPACE);
         1: text_bytes.push_back(CH_TAB);
         default: text_bytes.push_back(CH_NEWLINE);
      endcase
   endfunction

   function automatic void push_fragment();
      string punct[19];
      int    n;
      punct = '{"|", "=", "+", "*", "/", "^", ",", ";", ")", "[", "]", "{", "}",
                "-", "->", ":", ":=", "(", "("};
      if ($urandom_range(0, 23) == 0) begin
         text_bytes.push_back(8'($urandom_range(1, 255)));
         return;
      end
      case ($urandom_range(0, 11))
         0, 1: begin
            n = $urandom_range(1, 4);
            repeat (n) text_bytes.push_back(rand_digit());
            if ($urandom_range(0, 2) == 0) begin
               text_bytes.push_back(CH_DOT);
               n = $urandom_range(0, 3);
               repeat (n) text_bytes.push_back(rand_digit());
               if ($urandom_range(0, 7) == 0) text_bytes.push_back(CH_DOT);
            end
         end
         2, 3: begin
            text_bytes.push_back(rand_alpha());
            n = $urandom_range(0, 5);
            repeat (n) text_bytes.push_back(rand_word_char());
         end
         4: begin
            text_bytes.push_back(CH_COLON);
            text_bytes.push_back(rand_alpha());
            n = $urandom_range(0, 4);
            repeat (n) text_bytes.push_back($urandom_range(0, 2) ? rand_alpha() : rand_digit());
            if ($urandom_range(0, 5) == 0) text_bytes.push_back(CH_UNDER);
         end
         5: begin
            text_bytes.push_back(CH_HASH);
            n = $urandom_range(0, 4);
            repeat (n) text_bytes.push_back(rand_word_char());
         end
         6, 7: begin
            text_bytes.push_back(CH_QUOTE);
            n = $urandom_range(0, 5);
            repeat (n) text_bytes.push_back(rand_content_byte());
            if ($urandom_range(0, 7) != 0) text_bytes.push_back(CH_QUOTE);
         end
         8, 9, 10: push_string(punct[$urandom_range(0, 18)]);
         default: begin
            push_string($urandom_range(0, 3) == 0 ? "(*)" : "(*");
            n = $urandom_range(0, 5);
            repeat (n) begin
               case ($urandom_range(0, 3))
                  0: text_bytes.push_back(CH_STAR);
                  1: text_bytes.push_back(CH_RPAREN);
                  default: text_bytes.push_back(8'($urandom_range(1, 255)));
               endcase
            end
            if ($urandom_range(0, 9) != 0) push_string("*)");
         end
      endcase
   endfunction

   initial begin
      lex_result_type got;
      forever begin
         int stall;
         if ($urandom_range(0, 24) == 0) drain_burst = !drain_burst;
         stall = drain_burst ? 0 : $urandom_range(0, 5);
         @(negedge clock);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         got.result_kind = rsp_bus.result_kind;
         got.token_kind = rsp_bus.token_kind;
         got.value_byte = rsp_bus.value_byte;
         got.fault_code = rsp_bus.fault_code;
         got.run_last = rsp_bus.run_last;
         scoreboard.check_result(got);
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int sent;
      int nfrag;
      repeat (2) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      send_text("|=+*/^,;)[]{}->-:=(*)*):T_");
      send_text("1..");
      send_text("\"");
      send_byte(8'hFF, 1'b1);

      sent = 0;
      while (sent < RANDOM_BYTES) begin
         text_bytes.delete();
         send_burst = ($urandom_range(0, 4) == 0);
         nfrag = $urandom_range(1, 8);
         repeat (nfrag) begin
            push_fragment();
            if ($urandom_range(0, 1)) push_blank();
         end
         for (int i = 0; i < text_bytes.size(); i++)
            send_byte(text_bytes[i], i == text_bytes.size() - 1);
         sent += text_bytes.size();
      end

      @(negedge clock) req_bus.valid <= 1'b0;
      while (scoreboard.awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (scoreboard.fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/exlex_pkg.sv
sv/exlex_if.sv
sv/exlex_front.sv
sv/exlex_queue.sv
sv/exlex_back.sv
sv/expression_language_lexer_core.sv
bench/tb.sv
